### hw/rtl/vtbt_pkg.sv
// Package for the volume table block translator: sizes, codes and shared types.
package vtbt_pkg;

  // Table geometry
  localparam int NUM_SLOTS            = 8;
  localparam int SECTORS_PER_CYLINDER = 16;
  localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

  // Field widths fixed by the item format
  localparam int OP_W     = 1;
  localparam int VOL_W    = 3;
  localparam int BLK_W    = 20;
  localparam int CYL_W    = 16;
  localparam int SEC_W    = 4;
  localparam int LEN_W    = 20;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int USED_W   = 3;
  localparam int CYLO_W   = 17;
  localparam int SECO_W   = 4;

  // First sector plus block, with one carry bit
  localparam int T_W = ((SEC_W > BLK_W) ? SEC_W : BLK_W) + 1;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Operation codes
  localparam logic [OP_W-1:0] OP_CREATE    = 1'b0;
  localparam logic [OP_W-1:0] OP_TRANSLATE = 1'b1;

  // Volume kind meaning an empty slot
  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_KIND_NONE = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_RANGE     = 3'd4
  } status_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    status_t           status;
    logic [BLK_W-1:0]  block;
    logic [CYL_W-1:0]  cyl0;
    logic [SEC_W-1:0]  sec0;
    logic [LEN_W-1:0]  len;
  } cmd_t;

endpackage

### hw/rtl/vtbt_in_if.sv
// Request channel: valid/ready handshake with the input item fields.
interface vtbt_in_if;
  logic                             valid;
  logic                             ready;
  logic [vtbt_pkg::OP_W-1:0]        operation;
  logic [vtbt_pkg::VOL_W-1:0]       volume_index;
  logic [vtbt_pkg::BLK_W-1:0]       block_number;
  logic [vtbt_pkg::CYL_W-1:0]       start_cylinder;
  logic [vtbt_pkg::SEC_W-1:0]       start_sector;
  logic [vtbt_pkg::LEN_W-1:0]       length_sectors;
  logic [vtbt_pkg::KIND_W-1:0]      kind;

  modport source (output valid, operation, volume_index, block_number, start_cylinder,
                  start_sector, length_sectors, kind, input ready);
  modport sink   (input valid, operation, volume_index, block_number, start_cylinder,
                  start_sector, length_sectors, kind, output ready);
endinterface

### hw/rtl/vtbt_out_if.sv
// Result channel: valid/ready handshake with the result item fields.
interface vtbt_out_if;
  logic                             valid;
  logic                             ready;
  logic [vtbt_pkg::STATUS_W-1:0]    status;
  logic [vtbt_pkg::USED_W-1:0]      slot_used;
  logic [vtbt_pkg::CYLO_W-1:0]      cylinder_out;
  logic [vtbt_pkg::SECO_W-1:0]      sector_out;

  modport source (output valid, status, slot_used, cylinder_out, sector_out, input ready);
  modport sink   (input valid, status, slot_used, cylinder_out, sector_out, output ready);
endinterface

### hw/rtl/volume_table_block_translator.sv
// Path: a request accepted into the queue moves to the output register when the back end
// pops it and transfers from there; it waits longer while the result side stalls.
// Throughput: one request per cycle while the result side is ready, set by the
// combinational descriptor read and translate in the back end; a two-entry queue lets
// the front keep accepting while results wait.
// Reset (rst, synchronous): all slots become empty, queue and output are cleared.
module volume_table_block_translator (
  input  logic       clk,
  input  logic       rst,
  vtbt_in_if.sink    in_ch,
  vtbt_out_if.source out_ch
);

  // Descriptor contents need no reset; no clearing pass is run.
  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;
  vtbt_pkg::cmd_t front_cmd;
  vtbt_pkg::cmd_t head_cmd;

  vtbt_front u_front (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .q_full (q_full),
    .push   (push),
    .cmd    (front_cmd)
  );

  vtbt_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (front_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head_cmd)
  );

  vtbt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .head    (head_cmd),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

### hw/rtl/vtbt_front.sv
// Front end: accepts requests, tracks slot occupancy and classifies each request.
module vtbt_front (
  input  logic               clk,
  input  logic               rst,
  vtbt_in_if.sink            in_ch,
  input  logic               q_full,
  output logic               push,
  output vtbt_pkg::cmd_t     cmd
);

  logic [vtbt_pkg::KIND_W-1:0] slot_kind [vtbt_pkg::NUM_SLOTS];
  logic [vtbt_pkg::SLOT_W-1:0] free_slot;
  logic                        any_free;
  logic [vtbt_pkg::SLOT_W-1:0] vol_idx;
  logic                        vol_valid;
  logic                        create_ok;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  // Lowest free slot: scan from the top so the lowest index wins
  always_comb begin
    free_slot = '0;
    any_free  = 1'b0;
    for (int i = vtbt_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
      if (slot_kind[i] == vtbt_pkg::KIND_NONE) begin
        free_slot = vtbt_pkg::SLOT_W'(i);
        any_free  = 1'b1;
      end
    end
  end

  // Translate target must be inside the table and occupied
  assign vol_idx   = vtbt_pkg::SLOT_W'(in_ch.volume_index);
  assign vol_valid = (32'(in_ch.volume_index) < 32'(vtbt_pkg::NUM_SLOTS)) &&
                     (slot_kind[vol_idx] != vtbt_pkg::KIND_NONE);

  assign create_ok = (in_ch.kind != vtbt_pkg::KIND_NONE) && any_free;

  // Classification
  always_comb begin
    cmd.op    = in_ch.operation;
    cmd.block = in_ch.block_number;
    cmd.cyl0  = in_ch.start_cylinder;
    cmd.sec0  = in_ch.start_sector;
    cmd.len   = in_ch.length_sectors;
    if (in_ch.operation == vtbt_pkg::OP_CREATE) begin
      cmd.slot = free_slot;
      priority if (in_ch.kind == vtbt_pkg::KIND_NONE) begin
        cmd.status = vtbt_pkg::ST_KIND_NONE;
      end else if (!any_free) begin
        cmd.status = vtbt_pkg::ST_FULL;
      end else begin
        cmd.status = vtbt_pkg::ST_OK;
      end
    end else begin
      cmd.slot   = vol_idx;
      cmd.status = vol_valid ? vtbt_pkg::ST_OK : vtbt_pkg::ST_EMPTY;
    end
  end

  // Occupancy table, updated as soon as a create is accepted
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < vtbt_pkg::NUM_SLOTS; i++) begin
        slot_kind[i] <= vtbt_pkg::KIND_NONE;
      end
    end else if (push && in_ch.operation == vtbt_pkg::OP_CREATE && create_ok) begin
      slot_kind[free_slot] <= in_ch.kind;
    end
  end

endmodule

### hw/rtl/vtbt_queue.sv
// Two-entry command queue between front and back.
module vtbt_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  vtbt_pkg::cmd_t     push_cmd,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output vtbt_pkg::cmd_t     head
);

  vtbt_pkg::cmd_t              entries [vtbt_pkg::QDEPTH];
  logic [vtbt_pkg::QPTR_W-1:0] wr_ptr;
  logic [vtbt_pkg::QPTR_W-1:0] rd_ptr;
  logic [vtbt_pkg::QCNT_W-1:0] count;

  assign full  = (count == vtbt_pkg::QCNT_W'(vtbt_pkg::QDEPTH));
  assign empty = (count == '0);
  assign head  = entries[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_cmd;
  end

endmodule

### hw/rtl/vtbt_back.sv
// Back end: holds the volume descriptors, does the translation and drives results.
module vtbt_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  vtbt_pkg::cmd_t     head,
  output logic               pop,
  vtbt_out_if.source         out_ch
);

  logic [vtbt_pkg::CYL_W-1:0] slot_first_cylinder [vtbt_pkg::NUM_SLOTS];
  logic [vtbt_pkg::SEC_W-1:0] slot_first_sector   [vtbt_pkg::NUM_SLOTS];
  logic [vtbt_pkg::LEN_W-1:0] slot_length         [vtbt_pkg::NUM_SLOTS];

  logic                        out_valid;
  vtbt_pkg::status_t           status_next;
  logic [vtbt_pkg::USED_W-1:0] used_next;
  logic [vtbt_pkg::CYLO_W-1:0] cyl_next;
  logic [vtbt_pkg::SECO_W-1:0] sec_next;
  logic [vtbt_pkg::T_W-1:0]    t_sum;
  logic [vtbt_pkg::T_W-1:0]    t_quo;
  logic                        in_range;

  // Take a command when the output register is free or being drained
  assign pop          = !q_empty && (!out_valid || out_ch.ready);
  assign out_ch.valid = out_valid;

  // Translation of the addressed descriptor
  assign t_sum    = vtbt_pkg::T_W'(slot_first_sector[head.slot]) + vtbt_pkg::T_W'(head.block);
  assign t_quo    = vtbt_pkg::T_W'(t_sum / vtbt_pkg::SECTORS_PER_CYLINDER);
  assign in_range = head.block < slot_length[head.slot];

  // Result fields
  always_comb begin
    status_next = head.status;
    used_next   = '0;
    cyl_next    = '0;
    sec_next    = '0;
    if (head.op == vtbt_pkg::OP_CREATE) begin
      if (head.status == vtbt_pkg::ST_OK) used_next = vtbt_pkg::USED_W'(head.slot);
    end else if (head.status == vtbt_pkg::ST_OK) begin
      if (!in_range) begin
        status_next = vtbt_pkg::ST_RANGE;
      end else begin
        sec_next = vtbt_pkg::SECO_W'(t_sum % vtbt_pkg::SECTORS_PER_CYLINDER);
        cyl_next = vtbt_pkg::CYLO_W'(vtbt_pkg::CYLO_W'(slot_first_cylinder[head.slot]) +
                                     vtbt_pkg::CYLO_W'(t_quo));
      end
    end
  end

  // Descriptor write on a successful create
  always_ff @(posedge clk) begin
    if (pop && head.op == vtbt_pkg::OP_CREATE && head.status == vtbt_pkg::ST_OK) begin
      slot_first_cylinder[head.slot] <= head.cyl0;
      slot_first_sector[head.slot]   <= head.sec0;
      slot_length[head.slot]         <= head.len;
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (pop) begin
      out_ch.status       <= status_next;
      out_ch.slot_used    <= used_next;
      out_ch.cylinder_out <= cyl_next;
      out_ch.sector_out   <= sec_next;
    end
  end

endmodule

### sim/volume_table_block_translator_test.sv
// Testbench for volume_table_block_translator: create/translate traffic vs a shadow table.
`timescale 1ns / 100ps

module volume_table_block_translator_test;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 357;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS  = 10;

  typedef struct {
    logic [vtbt_pkg::OP_W-1:0]   operation;
    logic [vtbt_pkg::VOL_W-1:0]  volume_index;
    logic [vtbt_pkg::BLK_W-1:0]  block_number;
    logic [vtbt_pkg::CYL_W-1:0]  start_cylinder;
    logic [vtbt_pkg::SEC_W-1:0]  start_sector;
    logic [vtbt_pkg::LEN_W-1:0]  length_sectors;
    logic [vtbt_pkg::KIND_W-1:0] kind;
  } request_t;

  typedef struct {
    vtbt_pkg::status_t           status;
    logic [vtbt_pkg::USED_W-1:0] slot_used;
    logic [vtbt_pkg::CYLO_W-1:0] cylinder_out;
    logic [vtbt_pkg::SECO_W-1:0] sector_out;
  } reply_t;

  // Shadow copy of the volume table plus the replies still owed by the block
  class volume_table_shadow;
    logic [vtbt_pkg::KIND_W-1:0] slot_kind[vtbt_pkg::NUM_SLOTS];
    logic [vtbt_pkg::CYL_W-1:0]  slot_cyl[vtbt_pkg::NUM_SLOTS];
    logic [vtbt_pkg::SEC_W-1:0]  slot_sec[vtbt_pkg::NUM_SLOTS];
    logic [vtbt_pkg::LEN_W-1:0]  slot_len[vtbt_pkg::NUM_SLOTS];
    reply_t                      expected_replies[$];
    int                          mismatches;

    function new();
      foreach (slot_kind[i]) begin
        slot_kind[i] = vtbt_pkg::KIND_NONE;
        slot_cyl[i]  = '0;
        slot_sec[i]  = '0;
        slot_len[i]  = '0;
      end
      mismatches = 0;
    endfunction

    // Apply one request to the table and work out its reply
    function reply_t compute_reply(request_t r);
      reply_t      rep;
      int          free_slot;
      int unsigned offset;
      rep.status       = vtbt_pkg::ST_OK;
      rep.slot_used    = '0;
      rep.cylinder_out = '0;
      rep.sector_out   = '0;
      free_slot        = -1;
      if (r.operation == vtbt_pkg::OP_CREATE) begin
        // lowest empty slot wins
        for (int i = vtbt_pkg::NUM_SLOTS - 1; i >= 0; i--)
          if (slot_kind[i] == vtbt_pkg::KIND_NONE) free_slot = i;
        if (r.kind == vtbt_pkg::KIND_NONE) begin
          rep.status = vtbt_pkg::ST_KIND_NONE;
        end else if (free_slot < 0) begin
          rep.status = vtbt_pkg::ST_FULL;
        end else begin
          slot_kind[free_slot] = r.kind;
          slot_cyl[free_slot]  = r.start_cylinder;
          slot_sec[free_slot]  = r.start_sector;
          slot_len[free_slot]  = r.length_sectors;
          rep.slot_used        = vtbt_pkg::USED_W'(free_slot);
        end
      end else if (int'(r.volume_index) >= vtbt_pkg::NUM_SLOTS ||
                   slot_kind[r.volume_index] == vtbt_pkg::KIND_NONE) begin
        rep.status = vtbt_pkg::ST_EMPTY;
      end else if (r.block_number >= slot_len[r.volume_index]) begin
        rep.status = vtbt_pkg::ST_RANGE;
      end else begin
        offset           = int'(slot_sec[r.volume_index]) + int'(r.block_number);
        rep.sector_out   = vtbt_pkg::SECO_W'(offset % vtbt_pkg::SECTORS_PER_CYLINDER);
        rep.cylinder_out = vtbt_pkg::CYLO_W'(int'(slot_cyl[r.volume_index]) +
                                             offset / vtbt_pkg::SECTORS_PER_CYLINDER);
      end
      return rep;
    endfunction

    function void note_request(request_t r);
      expected_replies.push_back(compute_reply(r));
    endfunction

    function void check_reply(reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected reply: status %0d slot %0d cyl %0d sec %0d",
                   got.status, got.slot_used, got.cylinder_out, got.sector_out);
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status || got.slot_used !== want.slot_used ||
          got.cylinder_out !== want.cylinder_out || got.sector_out !== want.sector_out) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"bad reply: expected status %0d slot %0d cyl %0d sec %0d,",
                    " got status %0d slot %0d cyl %0d sec %0d"},
                   want.status, want.slot_used, want.cylinder_out, want.sector_out,
                   got.status, got.slot_used, got.cylinder_out, got.sector_out);
      end
    endfunction

    function void close_out();
      if (expected_replies.size() != 0) begin
        mismatches += expected_replies.size();
        $display("%0d replies never arrived", expected_replies.size());
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  int idle_pct    = 0;
  int stall_pct   = 0;
  int hold_left   = 0;
  int cycle_count = 0;

  volume_table_shadow shadow = new();

  vtbt_in_if  req_ch();
  vtbt_out_if res_ch();

  volume_table_block_translator dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (req_ch),
    .out_ch (res_ch)
  );

  // Clock
  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("volume_table_block_translator: mismatch");
      $finish;
    end
  end

  // Sample both channels at the rising edge
  always @(posedge clk) begin : transfer_monitor
    request_t seen;
    reply_t   got;
    if (!rst) begin
      if (req_ch.valid && req_ch.ready) begin
        seen.operation      = req_ch.operation;
        seen.volume_index   = req_ch.volume_index;
        seen.block_number   = req_ch.block_number;
        seen.start_cylinder = req_ch.start_cylinder;
        seen.start_sector   = req_ch.start_sector;
        seen.length_sectors = req_ch.length_sectors;
        seen.kind           = req_ch.kind;
        shadow.note_request(seen);
      end
      if (res_ch.valid && res_ch.ready) begin
        got.status       = vtbt_pkg::status_t'(res_ch.status);
        got.slot_used    = res_ch.slot_used;
        got.cylinder_out = res_ch.cylinder_out;
        got.sector_out   = res_ch.sector_out;
        shadow.check_reply(got);
      end
    end
  end

  // Reply side: random stalls, plus a long hold-off when requested
  initial begin : reply_sink
    res_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        res_ch.ready <= 1'b0;
        hold_left = hold_left - 1;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  function automatic request_t random_request();
    request_t r;
    r.operation      = vtbt_pkg::OP_W'($urandom_range(1));
    r.volume_index   = vtbt_pkg::VOL_W'($urandom);
    r.block_number   = vtbt_pkg::BLK_W'($urandom);
    r.start_cylinder = vtbt_pkg::CYL_W'($urandom);
    r.start_sector   = vtbt_pkg::SEC_W'($urandom);
    r.length_sectors = vtbt_pkg::LEN_W'($urandom);
    r.kind           = vtbt_pkg::KIND_W'($urandom);
    return r;
  endfunction

  // Offer one request; returns right after the rising edge of its transfer
  task automatic send_request(request_t r);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid          <= 1'b1;
    req_ch.operation      <= r.operation;
    req_ch.volume_index   <= r.volume_index;
    req_ch.block_number   <= r.block_number;
    req_ch.start_cylinder <= r.start_cylinder;
    req_ch.start_sector   <= r.start_sector;
    req_ch.length_sectors <= r.length_sectors;
    req_ch.kind           <= r.kind;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
  endtask

  task automatic send_create(logic [vtbt_pkg::KIND_W-1:0] k,
                             logic [vtbt_pkg::CYL_W-1:0] cyl,
                             logic [vtbt_pkg::SEC_W-1:0] sec,
                             logic [vtbt_pkg::LEN_W-1:0] len);
    request_t r;
    r                = random_request();
    r.operation      = vtbt_pkg::OP_CREATE;
    r.kind           = k;
    r.start_cylinder = cyl;
    r.start_sector   = sec;
    r.length_sectors = len;
    send_request(r);
  endtask

  task automatic send_translate(logic [vtbt_pkg::VOL_W-1:0] vol,
                                logic [vtbt_pkg::BLK_W-1:0] blk);
    request_t r;
    r              = random_request();
    r.operation    = vtbt_pkg::OP_TRANSLATE;
    r.volume_index = vol;
    r.block_number = blk;
    send_request(r);
  endtask

  // Random traffic: mostly translates aimed around each volume's length
  task automatic run_phase(int idle, int stall, int hold_at);
    request_t    r;
    int unsigned len;
    int unsigned pick;
    idle_pct  = idle;
    stall_pct = stall;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      r = random_request();
      if ($urandom_range(99) < 15) begin
        r.operation = vtbt_pkg::OP_CREATE;
      end else begin
        r.operation = vtbt_pkg::OP_TRANSLATE;
        len  = shadow.slot_len[r.volume_index];
        pick = $urandom_range(99);
        if (pick < 50 && len > 0)
          r.block_number = vtbt_pkg::BLK_W'($urandom_range(len - 1));
        else if (pick < 65)
          r.block_number = vtbt_pkg::BLK_W'(len + $urandom_range(2) - 1);
        else if (pick < 75)
          r.block_number = vtbt_pkg::BLK_W'($urandom_range(31));
      end
      if (i == hold_at) hold_left = HOLD_CYCLES;
      send_request(r);
    end
  endtask

  initial begin : stimulus
    req_ch.valid          = 1'b0;
    req_ch.operation      = vtbt_pkg::OP_CREATE;
    req_ch.volume_index   = '0;
    req_ch.block_number   = '0;
    req_ch.start_cylinder = '0;
    req_ch.start_sector   = '0;
    req_ch.length_sectors = '0;
    req_ch.kind           = vtbt_pkg::KIND_NONE;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table, rejected kind, then volumes at the extremes
    send_translate(vtbt_pkg::VOL_W'(0), '1);
    send_create(vtbt_pkg::KIND_NONE, '1, '1, '1);
    send_create(vtbt_pkg::KIND_W'(1), '1, '1, '1);
    send_create(vtbt_pkg::KIND_W'(2), '0, '0, '0);
    send_create(vtbt_pkg::KIND_W'(3), 16'h1234, 4'd7, 20'd1);
    send_create(vtbt_pkg::KIND_W'(1), 16'h00ff, 4'd8, 20'h80000);
    // Largest cylinder, length boundary, zero-length volume, sector carry
    send_translate(vtbt_pkg::VOL_W'(0), '0);
    send_translate(vtbt_pkg::VOL_W'(0), 20'hffffe);
    send_translate(vtbt_pkg::VOL_W'(0), 20'hfffff);
    send_translate(vtbt_pkg::VOL_W'(1), '0);
    send_translate(vtbt_pkg::VOL_W'(2), '0);
    send_translate(vtbt_pkg::VOL_W'(2), 20'd1);
    send_translate(vtbt_pkg::VOL_W'(3), 20'd7);
    send_translate(vtbt_pkg::VOL_W'(3), 20'd8);
    send_translate(vtbt_pkg::VOL_W'(7), '0);
    // Fill the rest of the table with random volumes
    for (int s = 4; s < vtbt_pkg::NUM_SLOTS; s++)
      send_create(vtbt_pkg::KIND_W'($urandom_range(3, 1)), vtbt_pkg::CYL_W'($urandom),
                  vtbt_pkg::SEC_W'($urandom),
                  (s < 6) ? vtbt_pkg::LEN_W'($urandom_range(64))
                          : vtbt_pkg::LEN_W'($urandom));
    // Full table, and a rejected kind on a full table
    send_create(vtbt_pkg::KIND_W'(3), '1, '1, '1);
    send_create(vtbt_pkg::KIND_NONE, '0, '0, '0);
    send_translate(vtbt_pkg::VOL_W'(7), '0);

    run_phase(0, 0, 100);
    run_phase(48, 0, -1);
    run_phase(0, 48, -1);
    run_phase(20, 20, -1);

    @(negedge clk);
    req_ch.valid <= 1'b0;
    while (shadow.expected_replies.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    shadow.close_out();
    if (shadow.mismatches == 0) begin
      $display("volume_table_block_translator: match");
    end else begin
      $display("volume_table_block_translator: mismatch");
    end
    $finish;
  end

endmodule
